// ===== rtl/core/veh_pkg.sv =====
// Shared types and constants for the variable-edge histogram.
package veh_pkg;

  localparam int DATA_W = 32;
  localparam int OUT_W  = 32;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_FILL = 2'd1,
    MODE_READ = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_FILL,
    KIND_READ,
    KIND_FAULT
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COUNT,
    ST_RESP
  } st_e;

endpackage

// ===== rtl/core/veh_front.sv =====
// Front end: accepts beats, classifies them and queues commands for the back end.
module veh_front import veh_pkg::*; #(
  parameter int MAX_BINS = 64,
  parameter int IDX_W    = 7
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               mode_i,
  input  logic signed [DATA_W-1:0] data_i,
  input  logic [IDX_W-1:0]         slot_i,
  input  logic [IDX_W-1:0]         nb_i,
  output logic                     q_valid_o,
  output kind_e                    q_kind_o,
  output logic [DATA_W-1:0]        q_data_o,
  output logic [IDX_W-1:0]         q_idx_o,
  input  logic                     q_pop_i
);

  localparam int Depth = 2;

  kind_e             kind_mem [Depth];
  logic [DATA_W-1:0] data_mem [Depth];
  logic [IDX_W-1:0]  idx_mem  [Depth];

  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  logic       pop;
  kind_e      kind;

  always_comb begin
    case (mode_i)
      MODE_LOAD: kind = (slot_i > IDX_W'(MAX_BINS)) ? KIND_FAULT : KIND_LOAD;
      MODE_FILL: kind = KIND_FILL;
      MODE_READ: kind = (slot_i > nb_i + IDX_W'(1)) ? KIND_FAULT : KIND_READ;
      default:   kind = KIND_FAULT;
    endcase
  end

  assign in_stall_o = (cnt_q == 2'(Depth));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_pop_i && q_valid_o;

  assign wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
  assign rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
  assign cnt_d    = cnt_q + 2'(push) - 2'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      kind_mem[wr_ptr_q] <= kind;
      data_mem[wr_ptr_q] <= data_i;
      idx_mem[wr_ptr_q]  <= slot_i;
    end
  end

  assign q_kind_o = kind_mem[rd_ptr_q];
  assign q_data_o = data_mem[rd_ptr_q];
  assign q_idx_o  = idx_mem[rd_ptr_q];

endmodule

// ===== rtl/core/veh_back.sv =====
// Back end: edge scan, count read-modify-write and result register.
module veh_back import veh_pkg::*; #(
  parameter int MAX_BINS   = 64,
  parameter int COUNT_BITS = 32,
  parameter int IDX_W      = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [IDX_W-1:0]  nb_i,
  input  logic              q_valid_i,
  input  kind_e             q_kind_i,
  input  logic [DATA_W-1:0] q_data_i,
  input  logic [IDX_W-1:0]  q_idx_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [IDX_W-1:0]  bin_index_o,
  output logic [OUT_W-1:0]  bin_count_o,
  output logic [OUT_W-1:0]  total_count_o,
  output logic              index_error_o
);

  localparam int EdgeDepth = MAX_BINS + 1;
  localparam int CntDepth  = MAX_BINS + 2;
  localparam int EIdxW     = $clog2(EdgeDepth);

  logic [DATA_W-1:0]     edge_mem [EdgeDepth];
  logic [COUNT_BITS-1:0] cnt_mem  [CntDepth];
  logic [CntDepth-1:0]   cnt_vld_q;

  st_e                   state_q, state_d;
  kind_e                 kind_q;
  logic [DATA_W-1:0]     data_q;
  logic [IDX_W-1:0]      idx_q;
  logic [IDX_W-1:0]      scan_q;
  logic [DATA_W-1:0]     edge_rd_q;
  logic [COUNT_BITS-1:0] cnt_rd_q;
  logic [COUNT_BITS-1:0] total_q;
  logic [OUT_W-1:0]      res_cnt_q;

  logic                  out_valid_q;
  logic [IDX_W-1:0]      out_idx_q;
  logic [OUT_W-1:0]      out_cnt_q;
  logic [OUT_W-1:0]      out_total_q;
  logic                  out_err_q;

  logic                  out_free;
  logic                  hit;
  logic                  last;
  logic                  found;
  logic [IDX_W-1:0]      bin_found;
  logic                  edge_re;
  logic [IDX_W-1:0]      edge_raddr;
  logic                  cnt_re;
  logic [IDX_W-1:0]      cnt_raddr;
  logic                  cnt_we;
  logic                  out_load;
  logic [COUNT_BITS-1:0] cnt_new;
  logic [COUNT_BITS-1:0] total_new;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign hit       = $signed(edge_rd_q) > $signed(data_q);
  assign last      = (scan_q == nb_i);
  assign found     = hit || last;
  assign bin_found = hit ? scan_q : scan_q + IDX_W'(1);
  assign cnt_new   = (&cnt_rd_q) ? cnt_rd_q : cnt_rd_q + COUNT_BITS'(1);
  assign total_new = (&total_q) ? total_q : total_q + COUNT_BITS'(1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          case (q_kind_i)
            KIND_FILL: state_d = ST_SCAN;
            KIND_READ: state_d = ST_COUNT;
            default:   state_d = ST_RESP;
          endcase
        end
      end
      ST_SCAN:  if (found) state_d = ST_COUNT;
      ST_COUNT: state_d = ST_RESP;
      ST_RESP:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o    = 1'b0;
    edge_re    = 1'b0;
    edge_raddr = '0;
    cnt_re     = 1'b0;
    cnt_raddr  = q_idx_i;
    cnt_we     = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        q_pop_o = q_valid_i;
        if (q_valid_i && q_kind_i == KIND_FILL) begin
          edge_re = 1'b1;
        end
        if (q_valid_i && q_kind_i == KIND_READ) begin
          cnt_re = 1'b1;
        end
      end
      ST_SCAN: begin
        if (found) begin
          cnt_re    = 1'b1;
          cnt_raddr = bin_found;
        end else begin
          edge_re    = 1'b1;
          edge_raddr = scan_q + IDX_W'(1);
        end
      end
      ST_COUNT: cnt_we = (kind_q == KIND_FILL);
      ST_RESP:  out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_vld_q   <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cnt_we) begin
        cnt_vld_q[idx_q] <= 1'b1;
        total_q          <= total_new;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      kind_q    <= q_kind_i;
      data_q    <= q_data_i;
      idx_q     <= q_idx_i;
      res_cnt_q <= '0;
    end
    if (edge_re) begin
      scan_q <= edge_raddr;
    end
    if (state_q == ST_SCAN && found) begin
      idx_q <= bin_found;
    end
    if (state_q == ST_COUNT) begin
      res_cnt_q <= (kind_q == KIND_FILL) ? OUT_W'(cnt_new) : OUT_W'(cnt_rd_q);
    end
    if (out_load) begin
      out_idx_q   <= idx_q;
      out_cnt_q   <= res_cnt_q;
      out_total_q <= OUT_W'(total_q);
      out_err_q   <= (kind_q == KIND_FAULT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_kind_i == KIND_LOAD) begin
      edge_mem[q_idx_i[EIdxW-1:0]] <= q_data_i;
    end
    if (edge_re) begin
      edge_rd_q <= edge_mem[edge_raddr[EIdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[idx_q] <= cnt_new;
    end
    if (cnt_re) begin
      cnt_rd_q <= cnt_vld_q[cnt_raddr] ? cnt_mem[cnt_raddr] : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign bin_index_o   = out_idx_q;
  assign bin_count_o   = out_cnt_q;
  assign total_count_o = out_total_q;
  assign index_error_o = out_err_q;

endmodule

// ===== rtl/core/variable_edge_histogram.sv =====
// Variable-edge histogram: edge load, sample fill and bin count readback.
//
// Input channel (in_valid_i / in_stall_o) carries one command beat: mode_i
// selects edge load, sample fill or bin readback; sample_or_edge_i is a
// signed Q16.16 value and slot_index_i the edge or bin index. Each beat gives
// exactly one result beat on the output channel (out_valid_o / out_stall_i).
// A two-entry command queue sits between the front end and the back end.
// Back end states per beat: a load or rejected command goes from IDLE to
// RESP, a readback passes COUNT on the way, and a fill passes SCAN and then
// COUNT. The scan reads one edge per cycle from the edge memory, at most
// num_bins+1 edges, until it finds one above the sample.
// The config channel (cfg_valid_i / cfg_ready_o) writes num_bins, clamped
// to 1..MAX_BINS; write it only while the block is idle.
// Reset clears all bin counts (per-bin valid flags), the fill total, the
// queue and the result register, and sets num_bins to MAX_BINS capped at
// 64. Edges are undefined until loaded. A stalled result holds in the output
// register while the queue keeps taking beats until it fills.
module variable_edge_histogram import veh_pkg::*; #(
  parameter int MAX_BINS   = 64,
  parameter int COUNT_BITS = 32,
  localparam int IdxW      = $clog2(MAX_BINS + 2)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               mode_i,
  input  logic signed [DATA_W-1:0] sample_or_edge_i,
  input  logic [IdxW-1:0]          slot_index_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [IdxW-1:0]          bin_index_o,
  output logic [OUT_W-1:0]         bin_count_o,
  output logic [OUT_W-1:0]         total_count_o,
  output logic                     index_error_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [IdxW-1:0]          cfg_data_i
);

  localparam int NbRst = (MAX_BINS < 64) ? MAX_BINS : 64;

  logic [IdxW-1:0]   nb_q, nb_d;
  logic              q_valid;
  kind_e             q_kind;
  logic [DATA_W-1:0] q_data;
  logic [IdxW-1:0]   q_idx;
  logic              q_pop;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    nb_d = nb_q;
    if (cfg_valid_i) begin
      if (cfg_data_i == '0) begin
        nb_d = IdxW'(1);
      end else if (cfg_data_i > IdxW'(MAX_BINS)) begin
        nb_d = IdxW'(MAX_BINS);
      end else begin
        nb_d = cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nb_q <= IdxW'(NbRst);
    end else begin
      nb_q <= nb_d;
    end
  end

  veh_front #(
    .MAX_BINS (MAX_BINS),
    .IDX_W    (IdxW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .data_i     (sample_or_edge_i),
    .slot_i     (slot_index_i),
    .nb_i       (nb_q),
    .q_valid_o  (q_valid),
    .q_kind_o   (q_kind),
    .q_data_o   (q_data),
    .q_idx_o    (q_idx),
    .q_pop_i    (q_pop)
  );

  veh_back #(
    .MAX_BINS   (MAX_BINS),
    .COUNT_BITS (COUNT_BITS),
    .IDX_W      (IdxW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .nb_i          (nb_q),
    .q_valid_i     (q_valid),
    .q_kind_i      (q_kind),
    .q_data_i      (q_data),
    .q_idx_i       (q_idx),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .bin_index_o   (bin_index_o),
    .bin_count_o   (bin_count_o),
    .total_count_o (total_count_o),
    .index_error_o (index_error_o)
  );

  a_err_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && index_error_o |-> bin_count_o == '0)
    else $error("rejected command returned a nonzero count");

  a_load_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !index_error_o && bin_index_o > nb_q + IdxW'(1) |-> bin_count_o == '0)
    else $error("result beyond the overflow bin carries a count");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_data_i != '0 && cfg_data_i <= IdxW'(MAX_BINS) |=>
      nb_q == $past(cfg_data_i))
    else $error("num_bins write lost");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for variable_edge_histogram: edge loads, fills, readback, num_bins.
`timescale 1ns / 1ps

module testbench;
  import veh_pkg::*;

  localparam int          MAX_BINS    = 64;
  localparam int          IDX_W       = 7;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;
  localparam logic [31:0] COUNT_TOP   = 32'hFFFF_FFFF;
  localparam longint      LIMIT       = 1_500_000;

  typedef struct packed {
    logic [1:0]       mode;
    logic [31:0]      data;
    logic [IDX_W-1:0] slot;
    logic             drain;
  } hist_cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] bin;
    logic [31:0]      count;
    logic [31:0]      total;
    logic             err;
  } bin_report_t;

  logic                     clk_i            = 1'b0;
  logic                     rst_ni           = 1'b0;
  logic                     in_valid_i       = 1'b0;
  logic                     in_stall_o;
  logic [1:0]               mode_i           = '0;
  logic signed [DATA_W-1:0] sample_or_edge_i = '0;
  logic [IDX_W-1:0]         slot_index_i     = '0;
  logic                     out_valid_o;
  logic                     out_stall_i      = 1'b0;
  logic [IDX_W-1:0]         bin_index_o;
  logic [OUT_W-1:0]         bin_count_o;
  logic [OUT_W-1:0]         total_count_o;
  logic                     index_error_o;
  logic                     cfg_valid_i      = 1'b0;
  logic                     cfg_ready_o;
  logic [IDX_W-1:0]         cfg_data_i       = '0;

  variable_edge_histogram #(
    .MAX_BINS  (MAX_BINS),
    .COUNT_BITS(32)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_i),
    .sample_or_edge_i(sample_or_edge_i),
    .slot_index_i    (slot_index_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .bin_index_o     (bin_index_o),
    .bin_count_o     (bin_count_o),
    .total_count_o   (total_count_o),
    .index_error_o   (index_error_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // predictor state
  logic [31:0]      edge_mem  [0:MAX_BINS];
  logic [31:0]      count_mem [0:MAX_BINS+1];
  logic [31:0]      fill_sum = '0;
  logic [IDX_W-1:0] num_bins_reg = 7'd64;

  // stimulus side view of loaded edges, used to aim samples
  logic [31:0]      gen_edges [0:MAX_BINS];

  hist_cmd_t   cmd_q[$];
  bin_report_t owed_results[$];

  int     n_offered = 0, n_accepted = 0, n_results = 0, n_mismatch = 0;
  int     n_fills = 0, n_loads = 0, n_reads = 0, n_rejects = 0;
  int     n_under = 0, n_over = 0, n_settings = 0;
  int     gap_left = 0, calm_left = 0;
  int     hold_left = 0, run_left = 0;
  bit     hold_done = 1'b0, run_stall = 1'b0;
  longint cycles = 0;

  initial begin
    for (int i = 0; i <= MAX_BINS + 1; i++) count_mem[i] = '0;
    for (int i = 0; i <= MAX_BINS; i++) begin
      edge_mem[i]  = '0;
      gen_edges[i] = '0;
    end
  end

  function automatic int bins_in_use(input logic [IDX_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_BINS) return MAX_BINS;
    return int'(v);
  endfunction

  function automatic bin_report_t bin_lookup_update(input hist_cmd_t c);
    bin_report_t r;
    int          lim;
    int          b;
    lim     = bins_in_use(num_bins_reg);
    r.bin   = c.slot;
    r.count = '0;
    r.err   = 1'b0;
    case (c.mode)
      MODE_LOAD: begin
        n_loads++;
        if (c.slot <= MAX_BINS) edge_mem[c.slot] = c.data;
        else r.err = 1'b1;
      end
      MODE_FILL: begin
        n_fills++;
        b = 0;
        while (b <= lim && $signed(edge_mem[b]) <= $signed(c.data)) b++;
        if (b == 0) n_under++;
        if (b == lim + 1) n_over++;
        if (count_mem[b] != COUNT_TOP) count_mem[b] = count_mem[b] + 1;
        if (fill_sum != COUNT_TOP) fill_sum = fill_sum + 1;
        r.bin   = IDX_W'(b);
        r.count = count_mem[b];
      end
      MODE_READ: begin
        n_reads++;
        if (c.slot <= lim + 1) r.count = count_mem[c.slot];
        else r.err = 1'b1;
      end
      default: r.err = 1'b1;
    endcase
    r.total = fill_sum;
    if (r.err) n_rejects++;
    return r;
  endfunction

  task automatic flag_mismatch(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    if (n_mismatch < 40)
      $display("%0t: %s mismatch on result %0d: got %0h, expected %0h",
               $time, field, n_results, got, want);
    n_mismatch++;
  endtask

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  function automatic int sender_gap();
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 59) == 0) begin
      calm_left = 60;
      return 0;
    end
    if ($urandom_range(0, 99) < 55) return 0;
    return idle_len();
  endfunction

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles,
               owed_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // command driver
  always @(negedge clk_i) begin : drive_cmds
    hist_cmd_t cur;
    if (rst_ni && !(in_valid_i && n_accepted != n_offered)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (cmd_q.size() > 0 && (!cmd_q[0].drain || owed_results.size() == 0)) begin
        cur = cmd_q.pop_front();
        mode_i           <= cur.mode;
        sample_or_edge_i <= cur.data;
        slot_index_i     <= cur.slot;
        in_valid_i       <= 1'b1;
        n_offered++;
        gap_left = sender_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result stall pattern, with one long hold-off to back up the block
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && n_results >= 250) begin
        hold_left = 150;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (run_left == 0) begin
          run_stall = run_stall ? 1'b0 : ($urandom_range(0, 2) != 0);
          if (run_stall) run_left = idle_len();
          else if ($urandom_range(0, 19) == 0) run_left = $urandom_range(40, 120);
          else run_left = $urandom_range(1, 12);
        end
        run_left--;
        out_stall_i <= run_stall;
      end
    end
  end

  // result checker and acceptance snoop
  always @(posedge clk_i) begin : watch
    bin_report_t want;
    hist_cmd_t   taken;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        n_results++;
        if (owed_results.size() == 0) begin
          flag_mismatch("unexpected beat, bin_index", 32'(bin_index_o), '0);
        end else begin
          want = owed_results.pop_front();
          if (bin_index_o !== want.bin)
            flag_mismatch("bin_index", 32'(bin_index_o), 32'(want.bin));
          if (bin_count_o !== want.count) flag_mismatch("bin_count", bin_count_o, want.count);
          if (total_count_o !== want.total)
            flag_mismatch("total_count", total_count_o, want.total);
          if (index_error_o !== want.err)
            flag_mismatch("index_error", 32'(index_error_o), 32'(want.err));
        end
      end
      if (cfg_valid_i && cfg_ready_o) num_bins_reg = cfg_data_i;
      if (in_valid_i && !in_stall_o) begin
        taken.mode  = mode_i;
        taken.data  = sample_or_edge_i;
        taken.slot  = slot_index_i;
        taken.drain = 1'b0;
        owed_results.push_back(bin_lookup_update(taken));
        n_accepted++;
      end
    end
  end

  task automatic queue_cmd(input logic [1:0] m, input logic [31:0] d,
                           input logic [IDX_W-1:0] sl, input logic drain);
    hist_cmd_t c;
    c.mode  = m;
    c.data  = d;
    c.slot  = sl;
    c.drain = drain;
    if (m == MODE_LOAD && sl <= MAX_BINS) gen_edges[sl] = d;
    cmd_q.push_back(c);
  endtask

  task automatic wait_idle();
    while (cmd_q.size() != 0 || n_accepted != n_offered || owed_results.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_num_bins(input logic [IDX_W-1:0] v);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  task automatic run_phase(input logic [IDX_W-1:0] setting, input int count);
    int          lim;
    int          k;
    int          r;
    logic        narrow;
    logic        drain;
    logic [31:0] s;
    int          vals[$];
    write_num_bins(setting);
    lim    = bins_in_use(setting);
    narrow = ($urandom_range(0, 3) == 0);
    for (k = 0; k <= lim; k++)
      vals.push_back(narrow ? int'($urandom_range(0, 1 << 20)) - (1 << 19) : int'($urandom()));
    vals.sort();
    for (k = 0; k <= lim; k++) queue_cmd(MODE_LOAD, vals[k], IDX_W'(k), 1'b0);
    for (k = 0; k < count; k++) begin
      r     = $urandom_range(0, 99);
      drain = ($urandom_range(0, 59) == 0);
      if (r < 55) begin
        if ($urandom_range(0, 9) < 6)
          s = gen_edges[$urandom_range(0, lim)] + $urandom_range(0, 4) - 2;
        else
          s = $urandom();
        queue_cmd(MODE_FILL, s, IDX_W'($urandom_range(0, 127)), drain);
      end else if (r < 70) begin
        queue_cmd(MODE_READ, $urandom(), IDX_W'($urandom_range(0, lim + 1)), drain);
      end else if (r < 78) begin
        queue_cmd(MODE_READ, $urandom(), IDX_W'($urandom_range(0, 127)), drain);
      end else if (r < 88) begin
        queue_cmd(MODE_LOAD, $urandom(), IDX_W'($urandom_range(0, MAX_BINS)), drain);
      end else if (r < 94) begin
        queue_cmd(MODE_LOAD, $urandom(), IDX_W'($urandom_range(0, 127)), drain);
      end else begin
        queue_cmd(MODE_UNUSED, $urandom(), IDX_W'($urandom_range(0, 127)), drain);
      end
    end
  endtask

  logic [IDX_W-1:0] cfg_plan [9] = '{7'd0, 7'd5, 7'd127, 7'd1, 7'd16, 7'd2, 7'd64, 7'd9, 7'd3};
  int               len_plan [9] = '{130, 180, 90, 120, 180, 130, 80, 180, 130};

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset num_bins is 64: slot 65 is the overflow bin, 66 is past it
    queue_cmd(MODE_READ, '0, 7'd65, 1'b0);
    queue_cmd(MODE_READ, '0, 7'd66, 1'b0);

    write_num_bins(7'd3);
    queue_cmd(MODE_LOAD, 32'hFFFE_0000, 7'd0, 1'b0);
    queue_cmd(MODE_LOAD, 32'hFFFF_0000, 7'd1, 1'b0);
    queue_cmd(MODE_LOAD, 32'h0001_8000, 7'd2, 1'b0);
    queue_cmd(MODE_LOAD, 32'h7FFF_FFFF, 7'd3, 1'b0);
    queue_cmd(MODE_LOAD, 32'h5555_5555, 7'd64, 1'b0);
    queue_cmd(MODE_LOAD, 32'hAAAA_AAAA, 7'd65, 1'b0);
    queue_cmd(MODE_LOAD, 32'h8000_0000, 7'd127, 1'b0);
    queue_cmd(MODE_FILL, 32'h8000_0000, 7'd0, 1'b0);   // underflow
    queue_cmd(MODE_FILL, 32'hFFFF_0000, 7'd0, 1'b0);   // equal to an edge
    queue_cmd(MODE_FILL, 32'h0000_0000, 7'd0, 1'b0);
    queue_cmd(MODE_FILL, 32'h0001_7FFF, 7'd0, 1'b0);
    queue_cmd(MODE_FILL, 32'h7FFF_FFFF, 7'd127, 1'b0); // overflow
    queue_cmd(MODE_FILL, 32'h7FFF_FFFE, 7'd0, 1'b0);
    queue_cmd(MODE_READ, '0, 7'd0, 1'b1);
    queue_cmd(MODE_READ, '0, 7'd4, 1'b0);
    queue_cmd(MODE_READ, '0, 7'd5, 1'b0);
    queue_cmd(MODE_READ, 32'hFFFF_FFFF, 7'd127, 1'b0);
    queue_cmd(MODE_READ, '0, 7'd2, 1'b0);
    queue_cmd(MODE_UNUSED, 32'h1234_5678, 7'd127, 1'b0);
    queue_cmd(MODE_UNUSED, '0, 7'd0, 1'b0);

    for (int p = 0; p < 9; p++) run_phase(cfg_plan[p], len_plan[p]);

    wait_idle();
    repeat (100) @(posedge clk_i);
    $display("Ran %0d command beats under %0d num_bins settings: %0d fills, %0d loads,",
             n_accepted, n_settings, n_fills, n_loads);
    $display("%0d reads, %0d rejected; %0d fills hit underflow, %0d hit overflow.",
             n_reads, n_rejects, n_under, n_over);
    if (n_mismatch == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
